// File: hdl/serial_boot_loader_receiver_unit_macros.svh
// Assertion macros used by the boot loader receiver checker.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef SERIAL_BOOT_LOADER_RECEIVER_UNIT_MACROS_SVH
`define SERIAL_BOOT_LOADER_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SBLR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SBLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sblr_pkg.sv
// Shared types and constants of the serial boot loader receiver.
// No dependencies; imported by every module of the block.
package sblr_pkg;

  // Reset values of the configuration registers
  localparam logic [31:0] LOAD_ADDR_RST = 32'h0008_1000;
  localparam logic [30:0] MIN_SIZE_RST  = 31'd64;
  localparam logic [30:0] MAX_SIZE_RST  = 31'd1048576;

  // Default pointer width
  localparam int ADDR_WIDTH_DEF = 32;

  // Configuration register indexes
  localparam logic [1:0] CFG_LOAD_ADDR = 2'd0;
  localparam logic [1:0] CFG_MIN_SIZE  = 2'd1;
  localparam logic [1:0] CFG_MAX_SIZE  = 2'd2;

  // Input operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // Status codes of a result
  localparam logic [1:0] ST_BUSY   = 2'd0;
  localparam logic [1:0] ST_OK     = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  // Acknowledge letters
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_K = 8'h4B;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_E = 8'h45;

  // Session phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SIZE,
    PH_LOAD,
    PH_HALT
  } phase_t;

  // Kind of result burst caused by one request
  typedef enum logic [2:0] {
    BK_REQ,   // 1, 2, 3
    BK_REJ,   // 'S','E'
    BK_ACK,   // 'O','K'
    BK_ACKZ,  // 'O','K', then load complete
    BK_ECHO   // echo plus memory write
  } burst_t;

  // Burst descriptor handed from the controller to the result queue
  typedef struct packed {
    burst_t      kind;
    logic [31:0] addr;
    logic [7:0]  data;
    logic        done;
  } desc_t;

  // Configuration register values
  typedef struct packed {
    logic [31:0] load_addr;
    logic [30:0] min_size;
    logic [30:0] max_size;
  } cfg_t;

endpackage

// File: hdl/sblr_ctrl.sv
// Session controller: phase, size gathering, payload pointer and count.
// Depends on sblr_pkg; produces at most one burst descriptor per request.
module sblr_ctrl
  import sblr_pkg::*;
#(
  parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic       op,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output logic       res_vld,
  output desc_t      res
);

  phase_t                  phase_r,  phase_nxt;
  logic [23:0]             size_r,   size_nxt;
  logic [1:0]              cnt_r,    cnt_nxt;
  logic [30:0]             left_r,   left_nxt;
  logic [ADDR_WIDTH-1:0]   ptr_r,    ptr_nxt;
  logic [31:0]             size_full;
  logic                    reject;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      size_r  <= '0;
      cnt_r   <= '0;
      left_r  <= '0;
      ptr_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      size_r  <= size_nxt;
      cnt_r   <= cnt_nxt;
      left_r  <= left_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  // Size check on the fourth byte; bit 31 set means negative
  assign size_full = {rx_byte, size_r};
  assign reject    = size_full[31] || (size_full[30:0] < cfg.min_size) ||
                     (size_full[30:0] > cfg.max_size);

  // Next state and burst selection
  always_comb begin
    phase_nxt = phase_r;
    size_nxt  = size_r;
    cnt_nxt   = cnt_r;
    left_nxt  = left_r;
    ptr_nxt   = ptr_r;
    res_vld   = 1'b0;
    res       = '{kind: BK_REQ, addr: '0, data: '0, done: 1'b0};
    if (acc) begin
      if (op == OP_START) begin
        phase_nxt = PH_SIZE;
        size_nxt  = '0;
        cnt_nxt   = '0;
        left_nxt  = '0;
        ptr_nxt   = ADDR_WIDTH'(cfg.load_addr);
        res_vld   = 1'b1;
        res.kind  = BK_REQ;
      end else begin
        case (phase_r)
          PH_SIZE: begin
            if (cnt_r != 2'd3) begin
              size_nxt = size_r | (24'(rx_byte) << {cnt_r, 3'b000});
              cnt_nxt  = cnt_r + 2'd1;
            end else begin
              cnt_nxt = '0;
              res_vld = 1'b1;
              if (reject) begin
                phase_nxt = PH_HALT;
                res.kind  = BK_REJ;
              end else begin
                left_nxt = size_full[30:0];
                if (size_full[30:0] == '0) begin
                  phase_nxt = PH_HALT;
                  res.kind  = BK_ACKZ;
                end else begin
                  phase_nxt = PH_LOAD;
                  res.kind  = BK_ACK;
                end
              end
            end
          end
          PH_LOAD: begin
            ptr_nxt  = ptr_r + 1'b1;
            left_nxt = left_r - 31'd1;
            res_vld  = 1'b1;
            res.kind = BK_ECHO;
            res.addr = 32'(ptr_r);
            res.data = rx_byte;
            if (left_r == 31'd1) begin
              phase_nxt = PH_HALT;
              res.done  = 1'b1;
            end
          end
          default: begin
            // idle or halted: byte is dropped
          end
        endcase
      end
    end
  end

endmodule

// File: hdl/serial_boot_loader_receiver_unit.sv
// Serial boot loader receiver, top level.
// Each result burst is registered into a slot of the burst queue.
// Throughput: one request per cycle while slot B of the burst queue is free;
// a request with k results (k up to 3) sends k beats; a two-entry burst queue decouples.
// Reset: rst_n synchronous active low; idle phase, config at reset values.
module serial_boot_loader_receiver_unit
  import sblr_pkg::*;
#(
  parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  // Input requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] op
  // Results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [0] send_en, [8:1] send_byte, [9] write_en,
                                  // [41:10] write_addr, [49:42] write_data,
                                  // [51:50] status, [55:52] zero
  output logic        out_tlast   // last
);

  cfg_t        cfg_r;
  logic        acc;
  logic        res_vld;
  desc_t       res;
  logic        a_vld_r, b_vld_r;
  desc_t       a_r, b_r;
  logic [1:0]  idx_r;
  logic        out_hs, a_done;
  logic        send_en, write_en, last;
  logic [7:0]  send_byte;
  logic [1:0]  status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.load_addr <= LOAD_ADDR_RST;
      cfg_r.min_size  <= MIN_SIZE_RST;
      cfg_r.max_size  <= MAX_SIZE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_LOAD_ADDR: cfg_r.load_addr <= cfg_wdata;
        CFG_MIN_SIZE:  cfg_r.min_size  <= cfg_wdata[30:0];
        CFG_MAX_SIZE:  cfg_r.max_size  <= cfg_wdata[30:0];
        default: begin
        end
      endcase
    end
  end

  assign in_tready = !b_vld_r;
  assign acc       = in_tvalid && in_tready;

  sblr_ctrl #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .op      (in_tuser),
    .rx_byte (in_tdata),
    .cfg     (cfg_r),
    .res_vld (res_vld),
    .res     (res)
  );

  assign out_hs = out_tvalid && out_tready;
  assign a_done = out_hs && last;

  // Two-slot burst queue: slot A drives the port, slot B waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      idx_r   <= '0;
    end else if (a_done) begin
      idx_r <= '0;
      if (b_vld_r) begin
        a_vld_r <= 1'b1;
        b_vld_r <= res_vld;
      end else begin
        a_vld_r <= res_vld;
      end
    end else begin
      if (out_hs) begin
        idx_r <= idx_r + 2'd1;
      end
      if (res_vld) begin
        if (a_vld_r) begin
          b_vld_r <= 1'b1;
        end else begin
          a_vld_r <= 1'b1;
        end
      end
    end
  end

  // Payload of the queue slots
  always_ff @(posedge clk) begin
    if (a_done && b_vld_r) begin
      a_r <= b_r;
      b_r <= res;
    end else if (a_done || !a_vld_r) begin
      a_r <= res;
    end else if (res_vld) begin
      b_r <= res;
    end
  end

  // Result beat decode from the head burst and beat index
  always_comb begin
    send_en   = 1'b1;
    send_byte = '0;
    write_en  = 1'b0;
    status    = ST_BUSY;
    last      = 1'b0;
    case (a_r.kind)
      BK_REQ: begin
        send_byte = 8'(idx_r) + 8'd1;
        last      = (idx_r == 2'd2);
      end
      BK_REJ: begin
        send_byte = (idx_r == 2'd0) ? CH_S : CH_E;
        status    = ST_REJECT;
        last      = (idx_r == 2'd1);
      end
      BK_ACK: begin
        send_byte = (idx_r == 2'd0) ? CH_O : CH_K;
        status    = ST_OK;
        last      = (idx_r == 2'd1);
      end
      BK_ACKZ: begin
        if (idx_r == 2'd2) begin
          send_en = 1'b0;
          status  = ST_DONE;
          last    = 1'b1;
        end else begin
          send_byte = (idx_r == 2'd0) ? CH_O : CH_K;
          status    = ST_OK;
        end
      end
      BK_ECHO: begin
        send_byte = a_r.data;
        write_en  = 1'b1;
        status    = a_r.done ? ST_DONE : ST_BUSY;
        last      = 1'b1;
      end
      default: begin
        send_en = 1'b0;
        last    = 1'b1;
      end
    endcase
  end

  assign out_tvalid = a_vld_r;
  assign out_tlast  = last;
  assign out_tdata  = {4'b0000, status,
                       write_en ? a_r.data : 8'h00,
                       write_en ? a_r.addr : 32'h0,
                       write_en, send_byte, send_en};

endmodule

// File: hdl/sblr_checker.sv
// Port-level checker for the serial boot loader receiver, with its bind.
// Depends on sblr_pkg and serial_boot_loader_receiver_unit_macros.svh.
`include "serial_boot_loader_receiver_unit_macros.svh"

module sblr_checker
  import sblr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast
);

  logic        stall;
  logic [56:0] beat;
  logic        wr_beat;
  logic        echo_ok;
  logic        wr_stat_ok;
  logic        rej_beat;
  logic        rej_end_ok;

  // Beat decode used by the properties
  assign stall      = out_tvalid && !out_tready;
  assign beat       = {out_tlast, out_tdata};
  assign wr_beat    = out_tvalid && out_tdata[9];
  assign echo_ok    = out_tdata[0] && (out_tdata[8:1] == out_tdata[49:42]) && out_tlast;
  assign wr_stat_ok = (out_tdata[51:50] == ST_BUSY) || (out_tdata[51:50] == ST_DONE);
  assign rej_beat   = out_tvalid && (out_tdata[51:50] == ST_REJECT);
  assign rej_end_ok = (out_tdata[8:1] == CH_E) == out_tlast;

  // A stalled result holds its payload
  `SBLR_ASSERT_NEXT(a_out_hold, stall, out_tvalid && $stable(beat), "result changed while stalled")

  // A memory write is always echoed with the same byte
  `SBLR_ASSERT_NOW(a_echo_match, wr_beat, echo_ok, "write not echoed")

  // Writes only happen in progress or on load completion
  `SBLR_ASSERT_NOW(a_write_status, wr_beat, wr_stat_ok, "write with acknowledge status")

  // A rejection ends on the 'E' letter and only there
  `SBLR_ASSERT_NOW(a_reject_end, rej_beat, rej_end_ok, "rejection burst framing")

endmodule

bind serial_boot_loader_receiver_unit sblr_checker u_sblr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
